### hdl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle, masked during reset
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication checked in the next cycle, masked during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// implication checked in the next cycle, live through reset
`define ASSERT_NEXT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/tbo_pkg.sv
`default_nettype none
package tbo_pkg;
    localparam int COORD_BITS_DEF = 32;
    localparam int HALF_RESET     = 32768;   // 0.5 in Q16.16
    localparam int OUT_BYTES      = 8;       // result word width
endpackage
`default_nettype wire

### hdl/triangle_box_overlap_sat_core.sv
// Triangle / cube overlap by 13 separating axes, fully pipelined.
// An accepted input word moves through the stage registers r1..r8 to the result word.
// Throughput: one word per cycle; a stall on the result side freezes all stages.
// Reset (i_rst_n low, synchronous): stage valids clear, box half size -> 0.5.
// Rate is set by the multiplier stages (about 34x34 per product per stage).
`default_nettype none
module triangle_box_overlap_sat_core #(
    parameter int COORD_BITS = tbo_pkg::COORD_BITS_DEF
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    // config: box_half_size, unsigned Q15.16
    input  wire logic                                    i_cfg_we,
    input  wire logic [COORD_BITS-2:0]                   i_cfg_wdata,
    // input stream
    input  wire logic                                    i_s_tvalid,
    output logic                                         o_s_tready,
    // tdata, low bit up: vert0_x,y,z, vert1_x,y,z, vert2_x,y,z,
    // box_center_x,y,z, each COORD_BITS, zero pad to whole bytes
    input  wire logic [((12*COORD_BITS+7)/8)*8-1:0]      i_s_tdata,
    // result stream
    output logic                                         o_m_tvalid,
    input  wire logic                                    i_m_tready,
    // tdata, low bit up: overlaps, zero pad
    output logic [tbo_pkg::OUT_BYTES-1:0]                o_m_tdata
);
    import tbo_pkg::*;

    localparam int W   = COORD_BITS;
    localparam int VW  = W + 1;           // vertex relative to center
    localparam int EW  = W + 2;           // edge vector
    localparam int BW  = VW + 1;          // box axis compare
    localparam int NPW = 2 * EW;          // normal partial product
    localparam int NW  = NPW + 1;         // normal component
    localparam int EPW = VW + EW;         // edge axis product
    localparam int EDW = EPW + 1;         // edge axis projection
    localparam int ERW = (W - 1) + EW + 1;// edge axis radius
    localparam int EC  = EDW + 1;         // edge axis compare
    localparam int LB  = W + 3;           // low split for wide multiplies
    localparam int PLW = VW + LB + 1;
    localparam int PHW = VW + NW - LB;
    localparam int SW  = NW + 2;          // sum of |n|
    localparam int RLW = (W - 1) + LB;
    localparam int RHW = (W - 1) + SW - LB;
    localparam int CW  = VW + NW + 4;     // normal compare

    // box half size register
    logic [W-2:0] r_half;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= (W-1)'(HALF_RESET);
        end else if (i_cfg_we) begin
            r_half <= i_cfg_wdata;
        end
    end

    // global advance: the pipe moves unless a result waits on a stalled sink
    logic        w_en;
    logic [8:1]  r_vld;
    assign w_en       = !r_vld[8] || i_m_tready;
    assign o_s_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[7:1], i_s_tvalid};
        end
    end

    // ---- stage 1: vertices relative to cube center
    logic signed [VW-1:0] n1_v [3][3];
    logic signed [VW-1:0] r1_v [3][3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                n1_v[i][k] = VW'($signed(i_s_tdata[(3*i+k)*W +: W]))
                           - VW'($signed(i_s_tdata[(9+k)*W +: W]));
            end
        end
    end

    // ---- stage 2: edges, box axes
    logic signed [EW-1:0] n2_e [3][3];
    logic signed [EW-1:0] r2_e [3][3];
    logic signed [VW-1:0] r2_v [3][3];
    logic                 n2_sep, r2_sep;
    logic signed [BW-1:0] w2_h, w2_lo, w2_hi, w2_p;
    always_comb begin
        w2_h   = BW'({1'b0, r_half});
        n2_sep = 1'b0;
        w2_lo  = '0;
        w2_hi  = '0;
        w2_p   = '0;
        for (int k = 0; k < 3; k++) begin
            n2_e[0][k] = EW'(r1_v[1][k]) - EW'(r1_v[0][k]);
            n2_e[1][k] = EW'(r1_v[2][k]) - EW'(r1_v[1][k]);
            n2_e[2][k] = EW'(r1_v[0][k]) - EW'(r1_v[2][k]);
            w2_lo = BW'(r1_v[0][k]);
            w2_hi = w2_lo;
            for (int i = 1; i < 3; i++) begin
                w2_p = BW'(r1_v[i][k]);
                if (w2_p < w2_lo) w2_lo = w2_p;
                if (w2_p > w2_hi) w2_hi = w2_p;
            end
            if ((w2_h < w2_lo) || (w2_hi < -w2_h)) n2_sep = 1'b1;
        end
    end

    // ---- stage 3: products for the normal and edge axes
    logic signed [NPW-1:0] n3_np [6];
    logic signed [NPW-1:0] r3_np [6];
    logic signed [EPW-1:0] n3_ep [3][3][3][2];
    logic signed [EPW-1:0] r3_ep [3][3][3][2];
    logic        [EW:0]    n3_es [3][3];
    logic        [EW:0]    r3_es [3][3];
    logic signed [VW-1:0]  r3_v0 [3];
    logic                  r3_sep;
    logic        [EW-1:0]  w3_a [3][3];
    always_comb begin
        n3_np[0] = NPW'(r2_e[0][1]) * NPW'(r2_e[1][2]);
        n3_np[1] = NPW'(r2_e[0][2]) * NPW'(r2_e[1][1]);
        n3_np[2] = NPW'(r2_e[0][2]) * NPW'(r2_e[1][0]);
        n3_np[3] = NPW'(r2_e[0][0]) * NPW'(r2_e[1][2]);
        n3_np[4] = NPW'(r2_e[0][0]) * NPW'(r2_e[1][1]);
        n3_np[5] = NPW'(r2_e[0][1]) * NPW'(r2_e[1][0]);
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                w3_a[i][k] = r2_e[i][k][EW-1] ? EW'(-r2_e[i][k]) : EW'(r2_e[i][k]);
            end
        end
        // axis j of edge i: p = v[u]*e[w] - v[w]*e[u], u=j+1, w=j+2 mod 3
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n3_es[i][j] = (EW+1)'(w3_a[i][(j+1)%3]) + (EW+1)'(w3_a[i][(j+2)%3]);
                for (int m = 0; m < 3; m++) begin
                    n3_ep[i][j][m][0] = EPW'(r2_v[m][(j+1)%3]) * EPW'(r2_e[i][(j+2)%3]);
                    n3_ep[i][j][m][1] = EPW'(r2_v[m][(j+2)%3]) * EPW'(r2_e[i][(j+1)%3]);
                end
            end
        end
    end

    // ---- stage 4: normal components, edge projections and radii
    logic signed [NW-1:0]  n4_n  [3];
    logic signed [NW-1:0]  r4_n  [3];
    logic signed [EDW-1:0] n4_pe [3][3][3];
    logic signed [EDW-1:0] r4_pe [3][3][3];
    logic        [ERW-1:0] n4_re [3][3];
    logic        [ERW-1:0] r4_re [3][3];
    logic signed [VW-1:0]  r4_v0 [3];
    logic                  r4_sep;
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n4_n[c] = NW'(r3_np[2*c]) - NW'(r3_np[2*c+1]);
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n4_re[i][j] = ERW'(r_half) * ERW'(r3_es[i][j]);
                for (int m = 0; m < 3; m++) begin
                    n4_pe[i][j][m] = EDW'(r3_ep[i][j][m][0]) - EDW'(r3_ep[i][j][m][1]);
                end
            end
        end
    end

    // ---- stage 5: edge axis verdict, split products of v0 . n, sum |n|
    logic signed [PLW-1:0] n5_pl [3];
    logic signed [PLW-1:0] r5_pl [3];
    logic signed [PHW-1:0] n5_ph [3];
    logic signed [PHW-1:0] r5_ph [3];
    logic        [SW-1:0]  n5_s, r5_s;
    logic                  n5_sep, r5_sep;
    logic signed [EC-1:0]  w5_lo, w5_hi, w5_p, w5_r;
    logic        [NW-1:0]  w5_a [3];
    always_comb begin
        n5_sep = r4_sep;
        w5_lo  = '0;
        w5_hi  = '0;
        w5_p   = '0;
        w5_r   = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                w5_r  = EC'(r4_re[i][j]);
                w5_lo = EC'(r4_pe[i][j][0]);
                w5_hi = w5_lo;
                for (int m = 1; m < 3; m++) begin
                    w5_p = EC'(r4_pe[i][j][m]);
                    if (w5_p < w5_lo) w5_lo = w5_p;
                    if (w5_p > w5_hi) w5_hi = w5_p;
                end
                if ((w5_r < w5_lo) || (w5_hi < -w5_r)) n5_sep = 1'b1;
            end
        end
        // all three vertices project alike onto the normal: use vertex 0
        for (int c = 0; c < 3; c++) begin
            w5_a[c]  = r4_n[c][NW-1] ? NW'(-r4_n[c]) : NW'(r4_n[c]);
            n5_pl[c] = PLW'(r4_v0[c]) * PLW'($signed({1'b0, r4_n[c][LB-1:0]}));
            n5_ph[c] = PHW'(r4_v0[c]) * PHW'($signed(r4_n[c][NW-1:LB]));
        end
        n5_s = SW'(w5_a[0]) + SW'(w5_a[1]) + SW'(w5_a[2]);
    end

    // ---- stage 6: normal projection sum, radius partials
    logic signed [CW-1:0]  n6_p, r6_p;
    logic        [RLW-1:0] n6_rl, r6_rl;
    logic        [RHW-1:0] n6_rh, r6_rh;
    logic                  r6_sep;
    always_comb begin
        n6_p = '0;
        for (int c = 0; c < 3; c++) begin
            n6_p = n6_p + (CW'(r5_ph[c]) <<< LB) + CW'(r5_pl[c]);
        end
        n6_rl = RLW'(r_half) * RLW'(r5_s[LB-1:0]);
        n6_rh = RHW'(r_half) * RHW'(r5_s[SW-1:LB]);
    end

    // ---- stage 7: normal radius
    logic signed [CW-1:0] n7_r, r7_r, r7_p;
    logic                 r7_sep;
    assign n7_r = $signed((CW'(r6_rh) << LB) + CW'(r6_rl));

    // ---- stage 8: normal verdict, result register
    logic n8_ovl, r8_ovl;
    assign n8_ovl = !r7_sep && !((r7_r < r7_p) || (r7_p < -r7_r));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_v   <= n1_v;
            r2_v   <= r1_v;
            r2_e   <= n2_e;
            r2_sep <= n2_sep;
            r3_np  <= n3_np;
            r3_ep  <= n3_ep;
            r3_es  <= n3_es;
            r3_v0  <= r2_v[0];
            r3_sep <= r2_sep;
            r4_n   <= n4_n;
            r4_pe  <= n4_pe;
            r4_re  <= n4_re;
            r4_v0  <= r3_v0;
            r4_sep <= r3_sep;
            r5_pl  <= n5_pl;
            r5_ph  <= n5_ph;
            r5_s   <= n5_s;
            r5_sep <= n5_sep;
            r6_p   <= n6_p;
            r6_rl  <= n6_rl;
            r6_rh  <= n6_rh;
            r6_sep <= r5_sep;
            r7_r   <= n7_r;
            r7_p   <= r6_p;
            r7_sep <= r6_sep;
            r8_ovl <= n8_ovl;
        end
    end

    assign o_m_tvalid = r_vld[8];
    assign o_m_tdata  = {(OUT_BYTES-1)'(0), r8_ovl};
endmodule
`default_nettype wire

### hdl/tbo_checker.sv
`default_nettype none
`include "assert_macros.svh"
module tbo_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_s_tready,
    input wire logic                         o_m_tvalid,
    input wire logic                         i_m_tready,
    input wire logic [tbo_pkg::OUT_BYTES-1:0] o_m_tdata
);
    import tbo_pkg::*;

    // a waiting result word stays valid
    `ASSERT_NEXT(a_hold_vld, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid)
    // input is never blocked while nothing waits at the output
    `ASSERT_SAME(a_rdy_free, i_clk, i_rst_n, !o_m_tvalid || i_m_tready, o_s_tready)
    // padding bits of the result word stay zero
    `ASSERT_SAME(a_pad_zero, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[OUT_BYTES-1:1] == '0)
    // reset empties the pipe
    `ASSERT_NEXT_RST(a_rst_empty, i_clk, !i_rst_n, !o_m_tvalid)
endmodule

bind triangle_box_overlap_sat_core tbo_checker u_tbo_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
`default_nettype wire
